/* rtl/ttlrc_pkg.sv */
// shared types and constants of the ttl record cache
`timescale 1ns / 1ps
package ttlrc_pkg;

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   localparam int MAX_RESULTS = 16;
   localparam int COUNT_W     = 5;
   localparam int IDX_W       = 8;    // covers the largest table of 256 slots
   localparam int EXP_W       = 33;

   typedef struct packed {
      logic        cmd;
      logic [31:0] now_seconds;
      logic [63:0] name_key;
      logic [15:0] record_type;
      logic [31:0] ttl_seconds;
      logic [15:0] mx_preference;
      logic [31:0] ipv4_address;
      logic [63:0] ipv6_high;
      logic [63:0] ipv6_low;
      logic [63:0] target_key;
      logic [4:0]  max_count;
   } req_payload_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] remaining_ttl;
      logic [63:0] out_name_key;
      logic [15:0] out_type;
      logic [15:0] out_mx_preference;
      logic [31:0] out_ipv4;
      logic [63:0] out_ipv6_high;
      logic [63:0] out_ipv6_low;
      logic [63:0] out_target_key;
      logic        last;
   } rsp_payload_type;

   // scan state that walks from cell to cell
   typedef struct packed {
      logic               active;
      logic               done;
      logic               have_free;
      logic [IDX_W-1:0]   free_idx;
      logic               have_soon;
      logic [IDX_W-1:0]   soon_idx;
      logic [EXP_W-1:0]   soon_exp;
      logic [COUNT_W-1:0] count;
   } token_type;

   // slot write at the end of a put scan
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [EXP_W-1:0] expiry;
   } commit_type;

endpackage

/* rtl/ttlrc_req_if.sv */
// request channel interface
`timescale 1ns / 1ps
interface ttlrc_req_if;
   import ttlrc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/ttlrc_rsp_if.sv */
// response channel interface
`timescale 1ns / 1ps
interface ttlrc_rsp_if;
   import ttlrc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/ttlrc_cell.sv */
// one table slot with its share of the scan
`timescale 1ns / 1ps
module ttlrc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  ttlrc_pkg::req_payload_type req,
   input  ttlrc_pkg::token_type       tok_in,
   input  ttlrc_pkg::commit_type      commit,
   output ttlrc_pkg::token_type       tok_out,
   output logic                       found,
   output ttlrc_pkg::rsp_payload_type found_rec
);
   import ttlrc_pkg::*;

   logic               valid_ff, valid_in;
   logic [EXP_W-1:0]   expiry_ff, expiry_in;
   logic [63:0]        name_ff, v6h_ff, v6l_ff, tgt_ff;
   logic [15:0]        type_ff, pref_ff;
   logic [31:0]        v4_ff;
   token_type          tok_ff, tok_in_nx;
   logic               live, key_match, full_match, my_write;
   logic [IDX_W-1:0]   my_idx;

   assign my_idx    = IDX_W'(CELL_INDEX);
   assign live      = expiry_ff > {1'b0, req.now_seconds};
   assign key_match = (name_ff == req.name_key) && (type_ff == req.record_type);
   assign full_match = key_match && (pref_ff == req.mx_preference) &&
                       (v4_ff == req.ipv4_address) && (v6h_ff == req.ipv6_high) &&
                       (v6l_ff == req.ipv6_low) && (tgt_ff == req.target_key);
   assign my_write  = commit.en && (commit.idx == my_idx);

   always_comb begin
      tok_in_nx = tok_in;
      valid_in  = valid_ff;
      expiry_in = expiry_ff;
      found     = 1'b0;
      if (tok_in.active) begin
         if (req.cmd == CMD_GET) begin
            if ((tok_in.count < req.max_count) && valid_ff && key_match) begin
               if (live) begin
                  found           = 1'b1;
                  tok_in_nx.count = tok_in.count + COUNT_W'(1);
               end else begin
                  valid_in = 1'b0;
               end
            end
         end else if (!tok_in.done) begin
            if (!valid_ff || !live) begin
               valid_in = 1'b0;
               if (!tok_in.have_free) begin
                  tok_in_nx.have_free = 1'b1;
                  tok_in_nx.free_idx  = my_idx;
               end
            end else if (full_match) begin
               expiry_in      = {1'b0, req.now_seconds} + {1'b0, req.ttl_seconds};
               tok_in_nx.done = 1'b1;
            end else if (!tok_in.have_soon || (expiry_ff < tok_in.soon_exp)) begin
               tok_in_nx.have_soon = 1'b1;
               tok_in_nx.soon_idx  = my_idx;
               tok_in_nx.soon_exp  = expiry_ff;
            end
         end
      end
      if (my_write) begin
         valid_in  = 1'b1;
         expiry_in = commit.expiry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         expiry_ff <= expiry_in;
         if (my_write) begin
            name_ff <= req.name_key;
            type_ff <= req.record_type;
            pref_ff <= req.mx_preference;
            v4_ff   <= req.ipv4_address;
            v6h_ff  <= req.ipv6_high;
            v6l_ff  <= req.ipv6_low;
            tgt_ff  <= req.target_key;
         end
      end
   end

   assign tok_out = tok_ff;

   always_comb begin
      found_rec = '0;
      if (found) begin
         found_rec.hit               = 1'b1;
         found_rec.remaining_ttl     = expiry_ff[31:0] - req.now_seconds;
         found_rec.out_name_key      = name_ff;
         found_rec.out_type          = type_ff;
         found_rec.out_mx_preference = pref_ff;
         found_rec.out_ipv4          = v4_ff;
         found_rec.out_ipv6_high     = v6h_ff;
         found_rec.out_ipv6_low      = v6l_ff;
         found_rec.out_target_key    = tgt_ff;
      end
   end

endmodule

/* rtl/ttl_record_cache_top.sv */
// ttl record cache: a chain of slot cells scanned by a travelling token
// a put or get runs from accept through the launch register and each cell's token register to the
//   finish and back to idle; a get hit is held until the next hit, the final one goes out at finish
// the block takes no new request until the token has left the last cell of the chain;
//   a zero ttl put is dropped at accept and leaves the block idle
// any cycle the response register is full and not taken freezes the whole scan
// reset: synchronous, clears all slot valid bits, the token and the response register
`timescale 1ns / 1ps
module ttl_record_cache_top #(
   parameter int SLOTS = 16
) (
   input logic         clock,
   input logic         reset,
   ttlrc_req_if.sink   req_bus,
   ttlrc_rsp_if.source rsp_bus
);
   import ttlrc_pkg::*;

   // captured request, broadcast to every cell
   req_payload_type req_ff, req_in;
   logic            busy_ff;
   token_type       launch_ff, launch_tok;

   // one held hit, so the last flag can be placed once the scan ends
   logic            pend_valid_ff, pend_valid_in;
   rsp_payload_type pend_ff, pend_in;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   token_type       tok_chain [SLOTS+1];
   logic [SLOTS-1:0] found_vec;
   rsp_payload_type rec_vec [SLOTS];
   rsp_payload_type any_rec;
   logic            any_found;
   token_type       fin;
   commit_type      commit;
   logic            advance, accept, busy_in;
   logic [4:0]      max_capped;

   // scan moves only when the response register can take a new item
   assign advance = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !busy_ff;
   assign accept  = req_bus.valid && !busy_ff;
   assign max_capped = (req_bus.payload.max_count > 5'(MAX_RESULTS)) ?
                       5'(MAX_RESULTS) : req_bus.payload.max_count;

   // request as stored, with the count already capped
   always_comb begin
      req_in           = req_bus.payload;
      req_in.max_count = max_capped;
   end

   // fresh token entering the first cell
   always_comb begin
      launch_tok        = '0;
      launch_tok.active = 1'b1;
   end

   assign tok_chain[0] = launch_ff;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ttlrc_cell #(.CELL_INDEX(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .req       (req_ff),
         .tok_in    (tok_chain[g]),
         .commit    (commit),
         .tok_out   (tok_chain[g+1]),
         .found     (found_vec[g]),
         .found_rec (rec_vec[g])
      );
   end

   // only the cell holding the token can report a hit
   always_comb begin
      any_rec = '0;
      for (int i = 0; i < SLOTS; i++) begin
         any_rec = any_rec | rec_vec[i];
      end
   end
   assign any_found = |found_vec;

   assign fin = tok_chain[SLOTS];

   // put finish: refresh already done in a cell, else free slot, else soonest expiry
   always_comb begin
      commit.en     = fin.active && (req_ff.cmd == CMD_PUT) && !fin.done;
      commit.idx    = fin.have_free ? fin.free_idx : fin.soon_idx;
      commit.expiry = {1'b0, req_ff.now_seconds} + {1'b0, req_ff.ttl_seconds};
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      busy_in       = busy_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (any_found) begin
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_in       = pend_ff;
            end
            pend_valid_in = 1'b1;
            pend_in       = any_rec;
         end
         if (fin.active) begin
            busy_in = 1'b0;
            if (req_ff.cmd == CMD_GET) begin
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  out_in = pend_ff;
               end else begin
                  out_in = '0;   // miss item
               end
               out_in.last = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         launch_ff     <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (accept) begin
            // a zero ttl put is taken and dropped
            if (!((req_bus.payload.cmd == CMD_PUT) &&
                  (req_bus.payload.ttl_seconds == 32'd0))) begin
               busy_ff   <= 1'b1;
               launch_ff <= launch_tok;
            end
         end else begin
            busy_ff <= busy_in;
            if (advance) begin
               launch_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      if (accept) begin
         req_ff <= req_in;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_ff;

   // no token may travel while the block is idle
   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (!launch_ff.active && !fin.active && !any_found))
      else $error("token active while idle");

   // a held hit exists only during a get scan
   a_pend_in_get: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (busy_ff && (req_ff.cmd == CMD_GET)))
      else $error("held hit outside a get");

   // a frozen response holds its value
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("response changed while stalled");

   // a put never produces a response item
   a_put_silent: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (req_ff.cmd == CMD_PUT) && !out_valid_ff) |=> !out_valid_ff)
      else $error("put produced a response");

endmodule
